>>> hdl/symbol_table_address_lookup_top_defines.svh
// ----------------------------------------------------------------------------
// symbol table address lookup assertion macros
// shared assertion forms, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SYMBOL_TABLE_ADDRESS_LOOKUP_TOP_DEFINES_SVH
`define SYMBOL_TABLE_ADDRESS_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define SLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// shared types and constants of the symbol table address lookup
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int unsigned EntryW = 88;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] desc;
    logic [31:0] value;
    logic [31:0] strx;
  } sym_entry_t;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_BAD_STR = 2'd1,
    ST_NO_FILE = 2'd2,
    ST_NO_LINE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_ENTRY_COUNT = 3'd0,
    CFG_STR_SIZE    = 3'd1,
    CFG_STR_OK      = 3'd2,
    CFG_FILE_CODE   = 3'd3,
    CFG_FUNC_CODE   = 3'd4,
    CFG_LINE_CODE   = 3'd5,
    CFG_INCL_CODE   = 3'd6,
    CFG_PARAM_CODE  = 3'd7
  } cfg_idx_e;

  localparam logic [7:0] FileCodeRst  = 8'd100;
  localparam logic [7:0] FuncCodeRst  = 8'd36;
  localparam logic [7:0] LineCodeRst  = 8'd68;
  localparam logic [7:0] InclCodeRst  = 8'd132;
  localparam logic [7:0] ParamCodeRst = 8'd160;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_WRITE,
    OP_LOAD,
    OP_FAIL_STR,
    OP_INIT_FILE,
    OP_MID,
    OP_SKIP,
    OP_RD_M,
    OP_DEC_M,
    OP_CMP,
    OP_NOHIT,
    OP_K_HI,
    OP_RD_K,
    OP_DEC_K,
    OP_SET_LO,
    OP_FAIL_FILE,
    OP_INIT_FUN,
    OP_RD_LO,
    OP_FUN_HIT,
    OP_INIT_LINE,
    OP_FAIL_LINE,
    OP_RD_HI,
    OP_LINE,
    OP_FILE_HIT,
    OP_ARG_INIT,
    OP_ARG_INC,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    logic str_ok;
    logic l_le_r;
    logic m_lt_l;
    logic kind_eq_type;
    logic hit;
    logic k_gt_lo;
    logic lo_is_zero;
    logic lo_le_hi;
    logic k_ge_lfile;
    logic bk_match;
    logic arg_ok;
    logic k_lt_rfun;
    logic kind_is_param;
    logic out_busy;
  } dp_status_t;

endpackage

>>> hdl/sla_if.sv
// ----------------------------------------------------------------------------
// sla_if
// request and result channel interfaces of the lookup
// ----------------------------------------------------------------------------
interface sla_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] entry_index;
  logic [7:0]  entry_kind;
  logic [15:0] entry_desc;
  logic [31:0] entry_value;
  logic [31:0] entry_strx;
  logic [31:0] query_addr;

  modport source (output valid, req_type, entry_index, entry_kind, entry_desc,
                  entry_value, entry_strx, query_addr, input ready);
  modport sink (input valid, req_type, entry_index, entry_kind, entry_desc,
                entry_value, entry_strx, query_addr, output ready);
endinterface

interface sla_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        fn_found;
  logic        fn_name_ok;
  logic [31:0] fn_name_offset;
  logic [31:0] fn_start;
  logic [15:0] line_number;
  logic        file_found;
  logic [31:0] file_name_offset;
  logic [11:0] arg_count;

  modport source (output valid, status, fn_found, fn_name_ok, fn_name_offset,
                  fn_start, line_number, file_found, file_name_offset, arg_count,
                  input ready);
  modport sink (input valid, status, fn_found, fn_name_ok, fn_name_offset,
                fn_start, line_number, file_found, file_name_offset, arg_count,
                output ready);
endinterface

>>> hdl/symbol_table_address_lookup_top.sv
// ----------------------------------------------------------------------------
// symbol_table_address_lookup_top
// debug symbol table with address to function, line and file lookup
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  req_i     in   req_type, entry_index, entry_kind/desc/value/strx, query_addr
//  rsp_o     out  status, fn_*, line_number, file_*, arg_count
//  cfg_*     in   write enable, register index, 32-bit data
//
//  a table write is done in the idle state; a query is paced by table reads
//  through the single ram port: three binary searches with backward type
//  scans, then a scan-back and arg count
//  reset clears control and sets config to its defaults; table contents are undefined until written
//  a finished result waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module symbol_table_address_lookup_top import sla_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  sla_req_if.sink     req_i,
  sla_rsp_if.source   rsp_o
);

  op_e        op;
  dp_status_t dp_status;

  sla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .status_i    (dp_status),
    .op_o        (op)
  );

  sla_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_i),
    .rsp        (rsp_o),
    .status_o   (dp_status)
  );

endmodule

>>> hdl/sla_ram.sv
// ----------------------------------------------------------------------------
// sla_ram
// single-port ram with registered read
// ----------------------------------------------------------------------------
module sla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/sla_dp.sv
// ----------------------------------------------------------------------------
// sla_dp
// lookup datapath: config registers, table ram, search indices, result register
// ----------------------------------------------------------------------------
module sla_dp import sla_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_e         op_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  sla_req_if.sink     req,
  sla_rsp_if.source   rsp,
  output dp_status_t  status_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned IW = AW + 2;

  logic [12:0] entry_count_q;
  logic [31:0] str_size_q;
  logic        str_ok_q;
  logic [7:0]  file_code_q, func_code_q, line_code_q, incl_code_q, param_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      str_size_q    <= '0;
      str_ok_q      <= 1'b0;
      file_code_q   <= FileCodeRst;
      func_code_q   <= FuncCodeRst;
      line_code_q   <= LineCodeRst;
      incl_code_q   <= InclCodeRst;
      param_code_q  <= ParamCodeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[12:0];
        CFG_STR_SIZE:    str_size_q    <= cfg_data_i;
        CFG_STR_OK:      str_ok_q      <= cfg_data_i[0];
        CFG_FILE_CODE:   file_code_q   <= cfg_data_i[7:0];
        CFG_FUNC_CODE:   func_code_q   <= cfg_data_i[7:0];
        CFG_LINE_CODE:   line_code_q   <= cfg_data_i[7:0];
        CFG_INCL_CODE:   incl_code_q   <= cfg_data_i[7:0];
        CFG_PARAM_CODE:  param_code_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // table ram
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  sym_entry_t    ram_wdata, rd;
  logic [EntryW-1:0] ram_rdata;

  assign rd = sym_entry_t'(ram_rdata);

  sla_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // search state
  logic signed [IW-1:0] l_q, r_q, lo_q, hi_q, m_q, mid_q, k_q;
  logic signed [IW-1:0] lfile_q, rfile_q, lfun_q, rfun_q;
  logic signed [IW-1:0] n_w;
  logic signed [IW:0]   sum_w;
  logic [31:0] addr_q, sa_q;
  logic [7:0]  type_q;
  logic        hit_q;

  // result state
  logic [1:0]  st_q;
  logic        fn_found_q, fn_ok_q, file_found_q;
  logic [31:0] fn_off_q, fn_start_q, file_off_q;
  logic [15:0] line_q;
  logic [11:0] args_q;

  // output register
  logic        out_vld_q;
  logic [1:0]  o_st_q;
  logic        o_fn_found_q, o_fn_ok_q, o_file_found_q;
  logic [31:0] o_fn_off_q, o_fn_start_q, o_file_off_q;
  logic [15:0] o_line_q;
  logic [11:0] o_args_q;

  assign n_w   = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                          : IW'(entry_count_q);
  assign sum_w = {l_q[IW-1], l_q} + {r_q[IW-1], r_q};

  assign ram_wdata = '{kind: req.entry_kind, desc: req.entry_desc,
                       value: req.entry_value, strx: req.entry_strx};

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = m_q[AW-1:0];
    case (op_i)
      OP_WRITE: begin
        ram_we   = (32'(req.entry_index) < 32'(TABLE_DEPTH));
        ram_addr = AW'(req.entry_index);
      end
      OP_RD_K:  ram_addr = k_q[AW-1:0];
      OP_RD_LO: ram_addr = lo_q[AW-1:0];
      OP_RD_HI: ram_addr = hi_q[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        addr_q       <= req.query_addr;
        st_q         <= ST_FOUND;
        fn_found_q   <= 1'b0;
        fn_ok_q      <= 1'b0;
        fn_off_q     <= '0;
        fn_start_q   <= req.query_addr;
        line_q       <= '0;
        file_found_q <= 1'b0;
        file_off_q   <= '0;
        args_q       <= '0;
      end
      OP_FAIL_STR:  st_q <= ST_BAD_STR;
      OP_FAIL_FILE: st_q <= ST_NO_FILE;
      OP_FAIL_LINE: st_q <= ST_NO_LINE;
      OP_INIT_FILE: begin
        l_q    <= '0;
        r_q    <= n_w - IW'(1);
        lo_q   <= '0;
        hi_q   <= n_w - IW'(1);
        type_q <= file_code_q;
        sa_q   <= addr_q;
        hit_q  <= 1'b0;
      end
      OP_MID: begin
        mid_q <= sum_w[IW:1];
        m_q   <= sum_w[IW:1];
      end
      OP_SKIP:  l_q <= mid_q + IW'(1);
      OP_DEC_M: m_q <= m_q - IW'(1);
      OP_CMP: begin
        hit_q <= 1'b1;
        if (rd.value < sa_q) begin
          lo_q <= m_q;
          l_q  <= mid_q + IW'(1);
        end else if (rd.value > sa_q) begin
          hi_q <= m_q - IW'(1);
          r_q  <= m_q - IW'(1);
        end else begin
          lo_q <= m_q;
          l_q  <= m_q;
          sa_q <= sa_q + 32'd1;
        end
      end
      OP_NOHIT:  hi_q <= lo_q - IW'(1);
      OP_K_HI:   k_q  <= hi_q;
      OP_DEC_K:  k_q  <= k_q - IW'(1);
      OP_SET_LO: lo_q <= k_q;
      OP_INIT_FUN: begin
        lfile_q <= lo_q;
        rfile_q <= hi_q;
        l_q     <= lo_q;
        r_q     <= hi_q;
        type_q  <= func_code_q;
        sa_q    <= addr_q;
        hit_q   <= 1'b0;
      end
      OP_FUN_HIT: begin
        fn_found_q <= 1'b1;
        fn_off_q   <= rd.strx;
        fn_ok_q    <= (rd.strx < str_size_q);
        fn_start_q <= rd.value;
        lfun_q     <= lo_q;
        rfun_q     <= hi_q;
        l_q        <= lo_q;
        r_q        <= hi_q;
        type_q     <= line_code_q;
        sa_q       <= addr_q - rd.value;
        hit_q      <= 1'b0;
      end
      OP_INIT_LINE: begin
        l_q    <= lfile_q;
        r_q    <= rfile_q;
        lo_q   <= lfile_q;
        hi_q   <= rfile_q;
        type_q <= line_code_q;
        sa_q   <= addr_q;
        hit_q  <= 1'b0;
      end
      OP_LINE: begin
        line_q <= rd.desc;
        k_q    <= lo_q;
      end
      OP_FILE_HIT: begin
        if (rd.strx < str_size_q) begin
          file_found_q <= 1'b1;
          file_off_q   <= rd.strx;
        end
      end
      OP_ARG_INIT: k_q <= lfun_q + IW'(1);
      OP_ARG_INC: begin
        k_q <= k_q + IW'(1);
        if (args_q != '1) begin
          args_q <= args_q + 12'd1;
        end
      end
      OP_PUBLISH: begin
        o_st_q         <= st_q;
        o_fn_found_q   <= fn_found_q;
        o_fn_ok_q      <= fn_ok_q;
        o_fn_off_q     <= fn_off_q;
        o_fn_start_q   <= fn_start_q;
        o_line_q       <= line_q;
        o_file_found_q <= file_found_q;
        o_file_off_q   <= file_off_q;
        o_args_q       <= args_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (op_i == OP_PUBLISH) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign rsp.valid            = out_vld_q;
  assign rsp.status           = o_st_q;
  assign rsp.fn_found         = o_fn_found_q;
  assign rsp.fn_name_ok       = o_fn_ok_q;
  assign rsp.fn_name_offset   = o_fn_off_q;
  assign rsp.fn_start         = o_fn_start_q;
  assign rsp.line_number      = o_line_q;
  assign rsp.file_found       = o_file_found_q;
  assign rsp.file_name_offset = o_file_off_q;
  assign rsp.arg_count        = o_args_q;

  always_comb begin
    status_o.str_ok        = str_ok_q;
    status_o.l_le_r        = (l_q <= r_q);
    status_o.m_lt_l        = (m_q < l_q);
    status_o.kind_eq_type  = (rd.kind == type_q);
    status_o.hit           = hit_q;
    status_o.k_gt_lo       = (k_q > lo_q);
    status_o.lo_is_zero    = (lo_q == '0);
    status_o.lo_le_hi      = (lo_q <= hi_q);
    status_o.k_ge_lfile    = (k_q >= lfile_q);
    status_o.bk_match      = (rd.kind == incl_code_q) ||
                             ((rd.kind == file_code_q) && (rd.value != '0));
    status_o.arg_ok        = fn_found_q && (lfun_q < rfun_q);
    status_o.k_lt_rfun     = (k_q < rfun_q);
    status_o.kind_is_param = (rd.kind == param_code_q);
    status_o.out_busy      = out_vld_q && !rsp.ready;
  end

endmodule

>>> hdl/sla_ctrl.sv
// ----------------------------------------------------------------------------
// sla_ctrl
// lookup sequencer: three typed searches, file scan-back, parameter count
// ----------------------------------------------------------------------------
`include "symbol_table_address_lookup_top_defines.svh"

module sla_ctrl import sla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_type_i,
  output logic       req_ready_o,
  input  dp_status_t status_i,
  output op_e        op_o
);

  typedef enum logic [17:0] {
    S_IDLE    = 18'b000000000000000001,
    S_START   = 18'b000000000000000010,
    S_LOOP    = 18'b000000000000000100,
    S_SCAN    = 18'b000000000000001000,
    S_SCAN_W  = 18'b000000000000010000,
    S_FIN     = 18'b000000000000100000,
    S_FK      = 18'b000000000001000000,
    S_FK_W    = 18'b000000000010000000,
    S_POST    = 18'b000000000100000000,
    S_FUN_W   = 18'b000000001000000000,
    S_LN_W    = 18'b000000010000000000,
    S_BK      = 18'b000000100000000000,
    S_BK_W    = 18'b000001000000000000,
    S_ARGS    = 18'b000010000000000000,
    S_AR      = 18'b000100000000000000,
    S_AR_W    = 18'b001000000000000000,
    S_OUT     = 18'b010000000000000000,
    S_SPARE   = 18'b100000000000000000
  } state_e;

  typedef enum logic [1:0] {
    PH_FILE,
    PH_FUN,
    PH_LINE
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (req_type_i) begin
            op_o    = OP_LOAD;
            state_d = S_START;
          end else begin
            op_o = OP_WRITE;
          end
        end
      end
      S_START: begin
        if (!status_i.str_ok) begin
          op_o    = OP_FAIL_STR;
          state_d = S_OUT;
        end else begin
          op_o    = OP_INIT_FILE;
          phase_d = PH_FILE;
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (status_i.l_le_r) begin
          op_o    = OP_MID;
          state_d = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (status_i.m_lt_l) begin
          op_o    = OP_SKIP;
          state_d = S_LOOP;
        end else begin
          op_o    = OP_RD_M;
          state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        if (status_i.kind_eq_type) begin
          op_o    = OP_CMP;
          state_d = S_LOOP;
        end else begin
          op_o    = OP_DEC_M;
          state_d = S_SCAN;
        end
      end
      S_FIN: begin
        if (status_i.hit) begin
          op_o    = OP_K_HI;
          state_d = S_FK;
        end else begin
          op_o    = OP_NOHIT;
          state_d = S_POST;
        end
      end
      S_FK: begin
        if (status_i.k_gt_lo) begin
          op_o    = OP_RD_K;
          state_d = S_FK_W;
        end else begin
          op_o    = OP_SET_LO;
          state_d = S_POST;
        end
      end
      S_FK_W: begin
        if (status_i.kind_eq_type) begin
          op_o    = OP_SET_LO;
          state_d = S_POST;
        end else begin
          op_o    = OP_DEC_K;
          state_d = S_FK;
        end
      end
      S_POST: begin
        case (phase_q)
          PH_FILE: begin
            if (status_i.lo_is_zero) begin
              op_o    = OP_FAIL_FILE;
              state_d = S_OUT;
            end else begin
              op_o    = OP_INIT_FUN;
              phase_d = PH_FUN;
              state_d = S_LOOP;
            end
          end
          PH_FUN: begin
            if (status_i.lo_le_hi) begin
              op_o    = OP_RD_LO;
              state_d = S_FUN_W;
            end else begin
              op_o    = OP_INIT_LINE;
              phase_d = PH_LINE;
              state_d = S_LOOP;
            end
          end
          default: begin
            if (status_i.lo_le_hi) begin
              op_o    = OP_RD_HI;
              state_d = S_LN_W;
            end else begin
              op_o    = OP_FAIL_LINE;
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_FUN_W: begin
        op_o    = OP_FUN_HIT;
        phase_d = PH_LINE;
        state_d = S_LOOP;
      end
      S_LN_W: begin
        op_o    = OP_LINE;
        state_d = S_BK;
      end
      S_BK: begin
        if (status_i.k_ge_lfile) begin
          op_o    = OP_RD_K;
          state_d = S_BK_W;
        end else begin
          state_d = S_ARGS;
        end
      end
      S_BK_W: begin
        if (status_i.bk_match) begin
          op_o    = OP_FILE_HIT;
          state_d = S_ARGS;
        end else begin
          op_o    = OP_DEC_K;
          state_d = S_BK;
        end
      end
      S_ARGS: begin
        if (status_i.arg_ok) begin
          op_o    = OP_ARG_INIT;
          state_d = S_AR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_AR: begin
        if (status_i.k_lt_rfun) begin
          op_o    = OP_RD_K;
          state_d = S_AR_W;
        end else begin
          state_d = S_OUT;
        end
      end
      S_AR_W: begin
        if (status_i.kind_is_param) begin
          op_o    = OP_ARG_INC;
          state_d = S_AR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          op_o    = OP_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_FILE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  `SLA_ASSERT_NEXT(a_query_starts, req_valid_i && req_ready_o && req_type_i, state_q == S_START, "query did not start")
  `SLA_ASSERT_NOW(a_scan_after_read, state_q == S_SCAN_W, $past(state_q) == S_SCAN, "scan wait without read")
  `SLA_ASSERT_NEXT(a_publish_valid, op_o == OP_PUBLISH, status_i.out_busy || state_q == S_IDLE, "publish lost")

endmodule

>>> tb/sv/symbol_table_address_lookup_top_tb.sv
// ----------------------------------------------------------------------------
// symbol_table_address_lookup_top_tb
// loads symbol tables of file, function, parameter and line entries over the
// request channel, then looks up code addresses and checks every result
// field against a local predictor of the three typed searches, the file
// scan-back and the argument count; sizes, type codes and bounds change
// between phases, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module symbol_table_address_lookup_top_tb;
  import sla_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 4096;

  typedef struct {
    logic        is_query;
    logic [11:0] idx;
    logic [7:0]  kind;
    logic [15:0] desc;
    logic [31:0] value;
    logic [31:0] strx;
    logic [31:0] addr;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic        fn_found;
    logic        fn_ok;
    logic [31:0] fn_off;
    logic [31:0] fn_start;
    logic [15:0] line;
    logic        file_found;
    logic [31:0] file_off;
    logic [11:0] args;
  } lookup_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  sla_req_if req_if ();
  sla_rsp_if rsp_if ();

  symbol_table_address_lookup_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  sym_entry_t  sym_tab [Depth];
  logic [12:0] n_entries = '0;
  logic [31:0] str_size = '0;
  logic        str_ok = 1'b0;
  logic [7:0]  c_file = FileCodeRst;
  logic [7:0]  c_func = FuncCodeRst;
  logic [7:0]  c_line = LineCodeRst;
  logic [7:0]  c_incl = InclCodeRst;
  logic [7:0]  c_param = ParamCodeRst;

  // stimulus side
  sym_entry_t plan [Depth];
  request_t   pending_q [$];
  lookup_t    lookup_q [$];
  int unsigned queued = 0;
  int unsigned taken = 0;
  int unsigned errors = 0;
  int unsigned rnd_items = 0;
  bit          quiet = 1'b0;

  function automatic sym_entry_t rd(longint i);
    if (i < 0 || i >= Depth) return '0;
    return sym_tab[i];
  endfunction

  function automatic void typed_search(ref longint lo, ref longint hi,
                                       input logic [7:0] ty, input logic [31:0] a);
    longint l, r, mid, m, k;
    bit hit;
    logic [31:0] key, v;
    l = lo;
    r = hi;
    hit = 0;
    key = a;
    while (l <= r) begin
      mid = (l + r) / 2;
      m = mid;
      while (m >= l && rd(m).kind != ty) m--;
      if (m < l) begin
        l = mid + 1;
        continue;
      end
      hit = 1;
      v = rd(m).value;
      if (v < key) begin
        lo = m;
        l = mid + 1;
      end else if (v > key) begin
        hi = m - 1;
        r = m - 1;
      end else begin
        lo = m;
        l = m;
        key = key + 32'd1;
      end
    end
    if (!hit) begin
      hi = lo - 1;
    end else begin
      k = hi;
      while (k > lo && rd(k).kind != ty) k--;
      lo = k;
    end
  endfunction

  function automatic lookup_t predict_lookup(logic [31:0] addr);
    lookup_t res;
    longint n, lfile, rfile, lfun, rfun, lline, rline, k;
    logic [31:0] laddr;
    sym_entry_t e;
    res = '0;
    res.status = ST_FOUND;
    res.fn_start = addr;
    n = (n_entries < Depth) ? n_entries : Depth;
    if (!str_ok) begin
      res.status = ST_BAD_STR;
      return res;
    end
    lfile = 0;
    rfile = n - 1;
    typed_search(lfile, rfile, c_file, addr);
    if (lfile == 0) begin
      res.status = ST_NO_FILE;
      return res;
    end
    lfun = lfile;
    rfun = rfile;
    laddr = addr;
    typed_search(lfun, rfun, c_func, addr);
    if (lfun <= rfun) begin
      e = rd(lfun);
      res.fn_found = 1'b1;
      res.fn_off = e.strx;
      res.fn_ok = e.strx < str_size;
      res.fn_start = e.value;
      laddr = addr - e.value;
      lline = lfun;
      rline = rfun;
    end else begin
      lline = lfile;
      rline = rfile;
    end
    typed_search(lline, rline, c_line, laddr);
    if (lline > rline) begin
      res.status = ST_NO_LINE;
      return res;
    end
    res.line = rd(rline).desc;
    while (lline >= lfile) begin
      e = rd(lline);
      if (e.kind == c_incl || (e.kind == c_file && e.value != 0)) break;
      lline--;
    end
    if (lline >= lfile) begin
      e = rd(lline);
      if (e.strx < str_size) begin
        res.file_found = 1'b1;
        res.file_off = e.strx;
      end
    end
    if (lfun < rfun) begin
      for (k = lfun + 1; k < rfun && rd(k).kind == c_param; k++)
        if (res.args != 12'hfff) res.args++;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // request driver
  int gap = 0;
  request_t cur;

  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.req_type <= 1'b0;
      req_if.entry_index <= '0;
      req_if.entry_kind <= '0;
      req_if.entry_desc <= '0;
      req_if.entry_value <= '0;
      req_if.entry_strx <= '0;
      req_if.query_addr <= '0;
      gap = 0;
    end else begin
      busy = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        if (cur.is_query) begin
          lookup_q.push_back(predict_lookup(cur.addr));
        end else begin
          sym_tab[cur.idx] = '{kind: cur.kind, desc: cur.desc, value: cur.value,
                               strx: cur.strx};
        end
        taken++;
        busy = 0;
        gap = pick_gap();
      end
      if (!busy) begin
        if (gap > 0) begin
          gap--;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          cur = pending_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_type <= cur.is_query;
          req_if.entry_index <= cur.idx;
          req_if.entry_kind <= cur.kind;
          req_if.entry_desc <= cur.desc;
          req_if.entry_value <= cur.value;
          req_if.entry_strx <= cur.strx;
          req_if.query_addr <= cur.addr;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t got, want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{status: status_e'(rsp_if.status), fn_found: rsp_if.fn_found,
                fn_ok: rsp_if.fn_name_ok, fn_off: rsp_if.fn_name_offset,
                fn_start: rsp_if.fn_start, line: rsp_if.line_number,
                file_found: rsp_if.file_found, file_off: rsp_if.file_name_offset,
                args: rsp_if.arg_count};
        if (lookup_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", got);
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch status %0d/%0d fn %b%b/%b%b off %h/%h start %h/%h",
                       want.status, got.status, want.fn_found, want.fn_ok,
                       got.fn_found, got.fn_ok, want.fn_off, got.fn_off,
                       want.fn_start, got.fn_start);
              $display("  line %0d/%0d file %b %h/%b %h args %0d/%0d",
                       want.line, got.line, want.file_found, want.file_off,
                       got.file_found, got.file_off, want.args, got.args);
            end
          end
        end
      end
      if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  task automatic push_entry(int i, logic [7:0] kind, logic [15:0] desc,
                            logic [31:0] value, logic [31:0] strx);
    request_t r;
    r = '{is_query: 1'b0, idx: i[11:0], kind: kind, desc: desc, value: value,
          strx: strx, addr: $urandom};
    plan[i] = '{kind: kind, desc: desc, value: value, strx: strx};
    pending_q.push_back(r);
    queued++;
  endtask

  task automatic push_query(logic [31:0] addr);
    request_t r;
    r = '{is_query: 1'b1, idx: $urandom, kind: $urandom, desc: $urandom,
          value: $urandom, strx: $urandom, addr: addr};
    pending_q.push_back(r);
    queued++;
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_ENTRY_COUNT: n_entries = data[12:0];
      CFG_STR_SIZE:    str_size = data;
      CFG_STR_OK:      str_ok = data[0];
      CFG_FILE_CODE:   c_file = data[7:0];
      CFG_FUNC_CODE:   c_func = data[7:0];
      CFG_LINE_CODE:   c_line = data[7:0];
      CFG_INCL_CODE:   c_incl = data[7:0];
      default:         c_param = data[7:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (taken != queued || lookup_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_strx();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 300);
    if (r < 8) return $urandom;
    return (r == 8) ? 32'h0 : 32'hffff_ffff;
  endfunction

  // mostly well-formed table of files, functions with parameters and relative lines
  task automatic build_table(int n);
    logic [31:0] pc, fn;
    int r;
    pc = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    fn = pc;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i == 0 && r < 50) r = 100;
      if (r < 8 || r == 100) begin
        pc += $urandom_range(0, 256);
        push_entry(i, c_file, $urandom, ($urandom_range(0, 7) == 0) ? 32'h0 : pc,
                   pick_strx());
      end else if (r < 18) begin
        pc += $urandom_range(0, 64);
        fn = pc;
        push_entry(i, c_func, $urandom, pc, pick_strx());
      end else if (r < 30) begin
        push_entry(i, c_param, $urandom, $urandom, pick_strx());
      end else if (r < 36) begin
        push_entry(i, c_incl, $urandom, pc, pick_strx());
      end else if (r < 92) begin
        pc += $urandom_range(0, 16);
        push_entry(i, c_line, $urandom, pc - fn, pick_strx());
      end else begin
        push_entry(i, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic random_queries(int n, int count);
    sym_entry_t a, b;
    int r;
    for (int q = 0; q < count; q++) begin
      a = plan[$urandom_range(0, n - 1)];
      b = plan[$urandom_range(0, n - 1)];
      r = $urandom_range(0, 99);
      if (r < 40) push_query(a.value + $urandom_range(0, 8));
      else if (r < 65) push_query(a.value + b.value);
      else if (r < 75) push_query(a.value - 32'd1);
      else if (r < 92) push_query($urandom);
      else push_query((r < 96) ? 32'h0 : 32'hffff_ffff);
    end
  endtask

  task automatic set_codes(logic [7:0] f, logic [7:0] fu, logic [7:0] l,
                           logic [7:0] inc, logic [7:0] p);
    cfg_write(CFG_FILE_CODE, f);
    cfg_write(CFG_FUNC_CODE, fu);
    cfg_write(CFG_LINE_CODE, l);
    cfg_write(CFG_INCL_CODE, inc);
    cfg_write(CFG_PARAM_CODE, p);
  endtask

  initial begin
    int n, r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // string table not yet valid
    push_query(32'h0);
    push_query(32'hffff_ffff);
    // two files, the first with a function, two parameters, lines and an included file
    push_entry(0, 8'h00, 16'h0000, 32'h0, 32'h0);
    push_entry(1, FileCodeRst, 16'h0, 32'h1000, 32'd5);
    push_entry(2, FuncCodeRst, 16'h0, 32'h1000, 32'd7);
    push_entry(3, ParamCodeRst, 16'h0, 32'h8, 32'd1);
    push_entry(4, ParamCodeRst, 16'h0, 32'hc, 32'd2);
    push_entry(5, LineCodeRst, 16'd10, 32'h0, 32'd0);
    push_entry(6, LineCodeRst, 16'hffff, 32'h10, 32'd0);
    push_entry(7, InclCodeRst, 16'h0, 32'h1010, 32'd9);
    push_entry(8, LineCodeRst, 16'd12, 32'h20, 32'd0);
    push_entry(9, FileCodeRst, 16'h0, 32'h2000, 32'd3);
    wait_idle();
    cfg_write(CFG_STR_OK, 32'd1);
    cfg_write(CFG_STR_SIZE, 32'd8);
    cfg_write(CFG_ENTRY_COUNT, 32'd0);
    push_query(32'h1000);
    wait_idle();
    cfg_write(CFG_ENTRY_COUNT, 32'd10);
    push_query(32'h1000);
    push_query(32'h1005);
    push_query(32'h1015);
    push_query(32'h1025);
    push_query(32'h0fff);
    push_query(32'h1fff);
    push_query(32'h2000);
    push_query(32'hffff_ffff);
    push_query(32'h0);
    wait_idle();
    set_codes(8'h00, 8'hff, 8'h01, 8'hfe, 8'h80);

    // random phases
    while (rnd_items < 920) begin
      wait_idle();
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 3);
      if (r == 0) set_codes(8'h00, 8'hff, 8'h01, 8'hfe, 8'h80);
      else if (r == 1) set_codes(FileCodeRst, FuncCodeRst, LineCodeRst, InclCodeRst,
                                 ParamCodeRst);
      else set_codes($urandom, $urandom, $urandom, $urandom, $urandom);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 4) : $urandom_range(8, 48);
      r = $urandom_range(0, 9);
      cfg_write(CFG_STR_SIZE, (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff
                                                 : $urandom_range(0, 300));
      cfg_write(CFG_STR_OK, ($urandom_range(0, 9) != 0));
      r = $urandom_range(0, 9);
      cfg_write(CFG_ENTRY_COUNT, (r == 0) ? 0 : (r == 1) ? 1 : n);
      build_table(n);
      random_queries(n, 30);
      rnd_items += n + 30;
    end
    wait_idle();

    if (errors == 0 && lookup_q.size() == 0) begin
      $display("symbol_table_address_lookup_top test passed");
    end else begin
      $display("symbol_table_address_lookup_top test failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("symbol_table_address_lookup_top test failed");
    $finish;
  end

endmodule
